// ===== rtl/l2c_pkg.sv =====
// shared types, widths and divider step functions for the lba to chs converter
`timescale 1ns / 1ps

package l2c_pkg;

	// address width taken from the request and width of the request port
	localparam int ADDR_W   = 32;
	localparam int IN_W     = 32;
	localparam int IN_BITS  = (ADDR_W < IN_W) ? ADDR_W : IN_W;

	// geometry widths
	localparam int HEADS_W  = 8;
	localparam int SPT_W    = 6;
	localparam int PC_W     = HEADS_W + SPT_W;
	localparam int CYL_W    = 10;
	localparam int WORD_W   = 16;

	// quotient bits resolved per pipeline stage
	localparam int DIV_STEP    = 4;
	localparam int DIV1_STAGES = (ADDR_W + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV1_W      = DIV1_STAGES * DIV_STEP;
	localparam int DIV2_STAGES = (PC_W + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV2_W      = DIV2_STAGES * DIV_STEP;

	// cylinder and head divider stages plus the output register
	localparam int LATENCY     = DIV1_STAGES + DIV2_STAGES + 1;

	// register map
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam logic REG_HEAD_COUNT = 1'b0;
	localparam logic REG_SPT        = 1'b1;
	localparam logic [HEADS_W-1:0] HEAD_COUNT_RST = 8'd255;
	localparam logic [SPT_W-1:0]   SPT_RST        = 6'd63;
	localparam logic [CYL_W-1:0]   CYL_LIMIT      = 10'd1023;

	// cylinder divider stage: partial remainder, dividend/quotient shift word
	typedef struct packed {
		logic [PC_W-1:0]   rem;
		logic [DIV1_W-1:0] dq;
		logic [PC_W-1:0]   per_cyl;
		logic [SPT_W-1:0]  spt;
	} cdiv_t;

	// head divider stage
	typedef struct packed {
		logic [SPT_W-1:0]  rem;
		logic [DIV2_W-1:0] dq;
		logic [CYL_W-1:0]  cyl;
		logic [SPT_W-1:0]  spt;
	} hdiv_t;

	typedef struct packed {
		logic [PC_W-1:0]     rem;
		logic [DIV_STEP-1:0] q;
	} cstep_t;

	typedef struct packed {
		logic [SPT_W-1:0]    rem;
		logic [DIV_STEP-1:0] q;
	} hstep_t;

	// DIV_STEP restoring division steps against the cylinder size
	function automatic cstep_t cdiv_step(input logic [PC_W-1:0] rem_in,
		input logic [DIV_STEP-1:0] bits, input logic [PC_W-1:0] divisor);
		cstep_t res;
		logic [PC_W:0] t;
		logic [PC_W-1:0] r;
		r = rem_in;
		res.q = '0;
		for (int i = DIV_STEP - 1; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
				res.q[i] = 1'b1;
			end
			r = t[PC_W-1:0];
		end
		res.rem = r;
		return res;
	endfunction

	// DIV_STEP restoring division steps against sectors per track
	function automatic hstep_t hdiv_step(input logic [SPT_W-1:0] rem_in,
		input logic [DIV_STEP-1:0] bits, input logic [SPT_W-1:0] divisor);
		hstep_t res;
		logic [SPT_W:0] t;
		logic [SPT_W-1:0] r;
		r = rem_in;
		res.q = '0;
		for (int i = DIV_STEP - 1; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
				res.q[i] = 1'b1;
			end
			r = t[SPT_W-1:0];
		end
		res.rem = r;
		return res;
	endfunction

endpackage

// ===== rtl/lba_to_chs_converter.sv =====
// lba to chs converter: geometry registers and pipelined divider chain
`timescale 1ns / 1ps

// Converts a logical block address into a head number and the packed
// sector/cylinder word of a partition table entry.
// Request channel: a request is taken at a clock edge where start is high
// and busy is low; busy is never raised, so one request can enter per cycle.
// Result channel: done is high for one cycle with head_number and
// sector_cylinder_word; the receiver cannot hold results off.
// Pipeline: one entry stage with the heads x sectors product, 8 cylinder
// divider stages resolving 4 quotient bits each, 4 head divider stages
// and one output register that drives done and the result.
// Throughput: one request per cycle, set by the fully pipelined dividers.
// Geometry is written through the APB port (head_count at 0, sectors per
// track at 4); zero acts as one. The user must write it only while no
// request is in flight; the block does not enforce it. Reset clears all
// valid bits and returns the geometry to 255 heads, 63 sectors per track.
module lba_to_chs_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [l2c_pkg::IN_W-1:0]       block_address,
	output logic        done,
	output logic [l2c_pkg::HEADS_W-1:0]    head_number,
	output logic [l2c_pkg::WORD_W-1:0]     sector_cylinder_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [l2c_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [l2c_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [l2c_pkg::CFG_DATA_W-1:0] prdata,
	output logic        pready
);

	logic [l2c_pkg::HEADS_W-1:0] head_count_q;
	logic [l2c_pkg::SPT_W-1:0]   spt_q;
	logic                        cfg_wr;

	logic                        vld_s1;
	l2c_pkg::cdiv_t              in_s1;
	logic [l2c_pkg::DIV1_W-1:0]  lba_ext;
	logic [l2c_pkg::HEADS_W-1:0] heads_eff;
	logic [l2c_pkg::SPT_W-1:0]   spt_eff;

	logic                        cdiv_vld_s [l2c_pkg::DIV1_STAGES];
	l2c_pkg::cdiv_t              cdiv_s     [l2c_pkg::DIV1_STAGES];
	logic                        hdiv_vld_s [l2c_pkg::DIV2_STAGES];
	l2c_pkg::hdiv_t              hdiv_s     [l2c_pkg::DIV2_STAGES];
	l2c_pkg::hdiv_t              hdiv_entry;

	logic                        done_q;
	logic [l2c_pkg::HEADS_W-1:0] head_q;
	logic [l2c_pkg::WORD_W-1:0]  word_q;
	logic [l2c_pkg::SPT_W-1:0]   sector;

	// apb port, always ready
	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_count_q <= l2c_pkg::HEAD_COUNT_RST;
			spt_q        <= l2c_pkg::SPT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				l2c_pkg::REG_HEAD_COUNT: head_count_q <= pwdata[l2c_pkg::HEADS_W-1:0];
				l2c_pkg::REG_SPT:        spt_q        <= pwdata[l2c_pkg::SPT_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[2])
			l2c_pkg::REG_HEAD_COUNT:
				prdata = {{(l2c_pkg::CFG_DATA_W-l2c_pkg::HEADS_W){1'b0}}, head_count_q};
			l2c_pkg::REG_SPT:
				prdata = {{(l2c_pkg::CFG_DATA_W-l2c_pkg::SPT_W){1'b0}}, spt_q};
			default: prdata = '0;
		endcase
	end

	// address masking and zero geometry treated as one
	always_comb begin
		lba_ext = '0;
		for (int i = 0; i < l2c_pkg::IN_BITS; i++) begin
			lba_ext[i] = block_address[i];
		end
	end

	assign heads_eff = (head_count_q == '0) ? l2c_pkg::HEADS_W'(1) : head_count_q;
	assign spt_eff   = (spt_q == '0) ? l2c_pkg::SPT_W'(1) : spt_q;

	// entry stage: capture request and heads x sectors product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			in_s1.rem     <= '0;
			in_s1.dq      <= lba_ext;
			in_s1.per_cyl <= l2c_pkg::PC_W'(heads_eff) * l2c_pkg::PC_W'(spt_eff);
			in_s1.spt     <= spt_eff;
		end
	end

	// cylinder divider: DIV_STEP quotient bits per stage
	for (genvar gk = 0; gk < l2c_pkg::DIV1_STAGES; gk++) begin : g_cdiv
		logic           vld_src;
		l2c_pkg::cdiv_t src;
		l2c_pkg::cstep_t st;

		if (gk == 0) begin : g_first
			assign vld_src = vld_s1;
			assign src     = in_s1;
		end else begin : g_next
			assign vld_src = cdiv_vld_s[gk-1];
			assign src     = cdiv_s[gk-1];
		end

		assign st = l2c_pkg::cdiv_step(src.rem,
			src.dq[l2c_pkg::DIV1_W-1 -: l2c_pkg::DIV_STEP], src.per_cyl);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cdiv_vld_s[gk] <= 1'b0;
			end else begin
				cdiv_vld_s[gk] <= vld_src;
			end
		end

		always_ff @(posedge clk) begin
			if (vld_src) begin
				cdiv_s[gk].rem     <= st.rem;
				cdiv_s[gk].dq      <= {src.dq[l2c_pkg::DIV1_W-l2c_pkg::DIV_STEP-1:0], st.q};
				cdiv_s[gk].per_cyl <= src.per_cyl;
				cdiv_s[gk].spt     <= src.spt;
			end
		end
	end

	// saturate cylinder and start the head division on the remainder
	always_comb begin
		hdiv_entry.rem = '0;
		hdiv_entry.dq  = {{(l2c_pkg::DIV2_W-l2c_pkg::PC_W){1'b0}},
			cdiv_s[l2c_pkg::DIV1_STAGES-1].rem};
		hdiv_entry.spt = cdiv_s[l2c_pkg::DIV1_STAGES-1].spt;
		if (|cdiv_s[l2c_pkg::DIV1_STAGES-1].dq[l2c_pkg::DIV1_W-1:l2c_pkg::CYL_W]) begin
			hdiv_entry.cyl = l2c_pkg::CYL_LIMIT;
		end else begin
			hdiv_entry.cyl = cdiv_s[l2c_pkg::DIV1_STAGES-1].dq[l2c_pkg::CYL_W-1:0];
		end
	end

	// head divider: DIV_STEP quotient bits per stage
	for (genvar gj = 0; gj < l2c_pkg::DIV2_STAGES; gj++) begin : g_hdiv
		logic           vld_src;
		l2c_pkg::hdiv_t src;
		l2c_pkg::hstep_t st;

		if (gj == 0) begin : g_first
			assign vld_src = cdiv_vld_s[l2c_pkg::DIV1_STAGES-1];
			assign src     = hdiv_entry;
		end else begin : g_next
			assign vld_src = hdiv_vld_s[gj-1];
			assign src     = hdiv_s[gj-1];
		end

		assign st = l2c_pkg::hdiv_step(src.rem,
			src.dq[l2c_pkg::DIV2_W-1 -: l2c_pkg::DIV_STEP], src.spt);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hdiv_vld_s[gj] <= 1'b0;
			end else begin
				hdiv_vld_s[gj] <= vld_src;
			end
		end

		always_ff @(posedge clk) begin
			if (vld_src) begin
				hdiv_s[gj].rem <= st.rem;
				hdiv_s[gj].dq  <= {src.dq[l2c_pkg::DIV2_W-l2c_pkg::DIV_STEP-1:0], st.q};
				hdiv_s[gj].cyl <= src.cyl;
				hdiv_s[gj].spt <= src.spt;
			end
		end
	end

	// output register: pack sector and cylinder
	assign sector = hdiv_s[l2c_pkg::DIV2_STAGES-1].rem + l2c_pkg::SPT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= hdiv_vld_s[l2c_pkg::DIV2_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (hdiv_vld_s[l2c_pkg::DIV2_STAGES-1]) begin
			head_q <= hdiv_s[l2c_pkg::DIV2_STAGES-1].dq[l2c_pkg::HEADS_W-1:0];
			word_q <= {hdiv_s[l2c_pkg::DIV2_STAGES-1].cyl[7:0],
				hdiv_s[l2c_pkg::DIV2_STAGES-1].cyl[9:8], sector};
		end
	end

	assign done                 = done_q;
	assign head_number          = head_q;
	assign sector_cylinder_word = word_q;

	// every result traces back to a request a fixed latency earlier
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, l2c_pkg::LATENCY + 1))
		else $error("result without matching request");

	// every request yields a result a fixed latency later
	a_req_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(l2c_pkg::LATENCY + 1) done)
		else $error("request lost in pipeline");

	// cylinder division leaves a remainder below the cylinder size
	a_cyl_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cdiv_vld_s[l2c_pkg::DIV1_STAGES-1] |->
		(cdiv_s[l2c_pkg::DIV1_STAGES-1].rem < cdiv_s[l2c_pkg::DIV1_STAGES-1].per_cyl))
		else $error("cylinder remainder out of range");

	// sector field is never zero and head never reaches 255
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sector_cylinder_word[5:0] != '0) && (head_number != 8'hFF))
		else $error("sector or head field out of range");

endmodule

// ===== tb/chs_result_checker.sv =====
// checker for the lba to chs converter: geometry tracking, prediction and result compare
`timescale 1ns / 1ps

module chs_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [l2c_pkg::IN_W-1:0]       block_address,
	input  logic                           done,
	input  logic [l2c_pkg::HEADS_W-1:0]    head_number,
	input  logic [l2c_pkg::WORD_W-1:0]     sector_cylinder_word,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [l2c_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [l2c_pkg::CFG_DATA_W-1:0] pwdata,
	output int                             fail_count,
	output int                             pending,
	output int                             results_seen,
	output int                             saturated_seen
);

	typedef struct {
		logic [l2c_pkg::IN_W-1:0]    lba;
		logic [l2c_pkg::HEADS_W-1:0] head;
		logic [l2c_pkg::WORD_W-1:0]  word;
		bit                          saturated;
	} chs_t;

	// geometry as the block should hold it
	logic [l2c_pkg::HEADS_W-1:0] heads_reg;
	logic [l2c_pkg::SPT_W-1:0]   spt_reg;

	chs_t expected_chs[$];
	int   errors;
	int   compared;
	int   saturated;

	// cylinder/head/sector split of one address, zero geometry acting as one
	function automatic chs_t chs_of_lba(input logic [l2c_pkg::IN_W-1:0] lba,
		input logic [l2c_pkg::HEADS_W-1:0] hc, input logic [l2c_pkg::SPT_W-1:0] spt);
		chs_t r;
		logic [63:0] addr, heads, sectors, per_cyl, cyl, rem, head, sector;
		addr    = 64'(lba[l2c_pkg::IN_BITS-1:0]);
		heads   = (hc == '0) ? 64'd1 : 64'(hc);
		sectors = (spt == '0) ? 64'd1 : 64'(spt);
		per_cyl = heads * sectors;
		cyl     = addr / per_cyl;
		rem     = addr % per_cyl;
		head    = rem / sectors;
		sector  = (rem % sectors) + 64'd1;
		r.saturated = (cyl > 64'(l2c_pkg::CYL_LIMIT));
		if (r.saturated)
			cyl = 64'(l2c_pkg::CYL_LIMIT);
		r.lba  = lba;
		r.head = head[l2c_pkg::HEADS_W-1:0];
		r.word = {cyl[7:0], cyl[9:8], sector[5:0]};
		return r;
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		chs_t exp_r;
		if (!arst_n) begin
			heads_reg <= l2c_pkg::HEAD_COUNT_RST;
			spt_reg   <= l2c_pkg::SPT_RST;
			expected_chs.delete();
			errors    = 0;
			compared  = 0;
			saturated = 0;
			fail_count     <= 0;
			pending        <= 0;
			results_seen   <= 0;
			saturated_seen <= 0;
		end else begin
			// compare an emitted result against the oldest request
			if (done) begin
				if (expected_chs.size() == 0) begin
					if (errors < 10)
						$display("[%0t] unexpected result: head %0d word %h", $realtime,
							head_number, sector_cylinder_word);
					errors++;
				end else begin
					exp_r = expected_chs.pop_front();
					compared++;
					if (exp_r.saturated)
						saturated++;
					if (head_number !== exp_r.head || sector_cylinder_word !== exp_r.word) begin
						if (errors < 10)
							$display("[%0t] lba %h: expected head %0d word %h, got head %0d word %h",
								$realtime, exp_r.lba, exp_r.head, exp_r.word,
								head_number, sector_cylinder_word);
						errors++;
					end
				end
			end

			// predict each accepted request
			if (start && !busy)
				expected_chs.push_back(chs_of_lba(block_address, heads_reg, spt_reg));

			// geometry register writes, only the low bits are kept
			if (psel && penable && pwrite && pready) begin
				if (paddr[l2c_pkg::CFG_ADDR_W-1:2] == l2c_pkg::REG_HEAD_COUNT)
					heads_reg <= pwdata[l2c_pkg::HEADS_W-1:0];
				else if (paddr[l2c_pkg::CFG_ADDR_W-1:2] == l2c_pkg::REG_SPT)
					spt_reg <= pwdata[l2c_pkg::SPT_W-1:0];
			end

			fail_count     <= errors;
			pending        <= expected_chs.size();
			results_seen   <= compared;
			saturated_seen <= saturated;
		end
	end

endmodule

// ===== tb/lba_to_chs_converter_tb.sv =====
// testbench top for the lba to chs converter: stimulus, register writes and verdict
`timescale 1ns / 1ps

module lba_to_chs_converter_tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 60;
	localparam int RANDOM_PHASES  = 8;
	localparam logic [l2c_pkg::CFG_ADDR_W-1:0] HEAD_COUNT_ADDR = {l2c_pkg::REG_HEAD_COUNT, 2'b00};
	localparam logic [l2c_pkg::CFG_ADDR_W-1:0] SPT_ADDR        = {l2c_pkg::REG_SPT, 2'b00};

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [l2c_pkg::IN_W-1:0]       block_address;
	logic                           done;
	logic [l2c_pkg::HEADS_W-1:0]    head_number;
	logic [l2c_pkg::WORD_W-1:0]     sector_cylinder_word;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [l2c_pkg::CFG_ADDR_W-1:0] paddr;
	logic [l2c_pkg::CFG_DATA_W-1:0] pwdata;
	logic [l2c_pkg::CFG_DATA_W-1:0] prdata;
	logic                           pready;

	int fail_count;
	int pending;
	int results_seen;
	int saturated_seen;
	int requests_sent;
	int geometries;
	int idle_cycles;
	bit no_idle;

	// geometry currently programmed, used to aim addresses at boundaries
	logic [l2c_pkg::HEADS_W-1:0] cur_heads;
	logic [l2c_pkg::SPT_W-1:0]   cur_spt;

	lba_to_chs_converter dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.block_address        (block_address),
		.done                 (done),
		.head_number          (head_number),
		.sector_cylinder_word (sector_cylinder_word),
		.psel                 (psel),
		.penable              (penable),
		.pwrite               (pwrite),
		.paddr                (paddr),
		.pwdata               (pwdata),
		.prdata               (prdata),
		.pready               (pready)
	);

	chs_result_checker chs_check (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.block_address        (block_address),
		.done                 (done),
		.head_number          (head_number),
		.sector_cylinder_word (sector_cylinder_word),
		.psel                 (psel),
		.penable              (penable),
		.pwrite               (pwrite),
		.pready               (pready),
		.paddr                (paddr),
		.pwdata               (pwdata),
		.fail_count           (fail_count),
		.pending              (pending),
		.results_seen         (results_seen),
		.saturated_seen       (saturated_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("lba_to_chs_converter verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// addresses spread over whole range, cylinder range, track edges and top of range
	function automatic logic [l2c_pkg::IN_W-1:0] pick_lba();
		int unsigned heads, sectors, per_cyl;
		heads   = (cur_heads == '0) ? 1 : cur_heads;
		sectors = (cur_spt == '0) ? 1 : cur_spt;
		per_cyl = heads * sectors;
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, per_cyl * 1024 - 1);
			2: return $urandom_range(0, 1030) * per_cyl + $urandom_range(0, heads - 1) * sectors
				+ ($urandom_range(0, 1) ? sectors - 1 : 0);
			default: return ~l2c_pkg::IN_W'($urandom_range(0, 1023));
		endcase
	endfunction

	// one request, then an optional gap
	task automatic send_lba(input logic [l2c_pkg::IN_W-1:0] lba);
		int gap;
		start         <= 1'b1;
		block_address <= lba;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start         <= 1'b0;
			block_address <= $urandom();
			repeat (gap) @(negedge clk);
		end
	endtask

	// stop sending and let every request come back
	task automatic drain();
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (l2c_pkg::LATENCY) @(negedge clk);
	endtask

	// setup and access phase of one register write
	task automatic reg_write(input logic [l2c_pkg::CFG_ADDR_W-1:0] addr,
		input logic [l2c_pkg::CFG_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_geometry(input logic [l2c_pkg::CFG_DATA_W-1:0] heads_word,
		input logic [l2c_pkg::CFG_DATA_W-1:0] spt_word);
		drain();
		reg_write(HEAD_COUNT_ADDR, heads_word);
		reg_write(SPT_ADDR, spt_word);
		cur_heads = heads_word[l2c_pkg::HEADS_W-1:0];
		cur_spt   = spt_word[l2c_pkg::SPT_W-1:0];
		geometries++;
	endtask

	// stimulus
	initial begin
		logic [l2c_pkg::IN_W-1:0] directed_lba[$];
		arst_n        = 1'b0;
		start         = 1'b0;
		block_address = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		requests_sent = 0;
		geometries    = 1;
		no_idle       = 1'b0;
		cur_heads     = l2c_pkg::HEAD_COUNT_RST;
		cur_spt       = l2c_pkg::SPT_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry: track, head and cylinder edges, saturation, address extremes
		directed_lba = '{32'd0, 32'd1, 32'd62, 32'd63, 32'd64, 32'd16064, 32'd16065,
			32'd16434495, 32'd16450559, 32'd16450560, 32'hFFFFFFFF, 32'h80000000,
			32'h55555555, 32'hAAAAAAAA};
		foreach (directed_lba[i])
			send_lba(directed_lba[i]);

		// zero geometry with junk in the upper data bits
		set_geometry(32'hFFFFFF00, 32'hFFFFFFC0);
		directed_lba = '{32'd0, 32'd5, 32'd1023, 32'd1024, 32'hFFFFFFFF};
		foreach (directed_lba[i])
			send_lba(directed_lba[i]);

		// random phases over several geometries
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: set_geometry(32'h000000FF, 32'h0000003F);
				1: set_geometry(32'h00000001, 32'h00000001);
				2: set_geometry(32'hFFFFFF01, 32'hFFFFFF3F);
				3: set_geometry(32'h00000100, 32'h00000040);
				default: set_geometry($urandom(), $urandom());
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_lba(pick_lba());
		end
		no_idle = 1'b0;

		// final drain and verdict
		drain();
		repeat (l2c_pkg::LATENCY + 4) @(posedge clk);
		$display("run covered %0d requests over %0d geometry settings", requests_sent, geometries);
		$display("%0d results compared, %0d with the cylinder clamped", results_seen,
			saturated_seen);
		if (fail_count == 0 && pending == 0)
			$display("lba_to_chs_converter verification clean");
		else
			$display("lba_to_chs_converter verification failed");
		$finish;
	end

endmodule
